@@ hdl/positional_list_insert_read_erase_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the positional list
// Shared forms for concurrent checks clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_INSERT_READ_ERASE_MACROS_SVH
`define POSITIONAL_LIST_INSERT_READ_ERASE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define PLIST_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PLIST_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/plist_pkg.sv @@
// ----------------------------------------------------------------------------
// Positional list package
// Widths, request and status codes, and the command and status bundles that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package plist_pkg;

	localparam int DEPTH_DEF     = 64;
	localparam int WORD_BITS_DEF = 32;
	localparam int VALUE_W       = 32;
	localparam int MODE_W        = 2;
	localparam int STATUS_W      = 2;

	localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_READ   = 2'd1;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic                accept;
		logic                shift;
		logic                ins_write;
		logic                cnt_inc;
		logic                cnt_dec;
		logic                out_load;
		logic                out_rd;
		logic [STATUS_W-1:0] status;
	} cmd_t;

	typedef struct packed {
		logic is_insert;
		logic is_read;
		logic range_err;
		logic full;
		logic rem_zero;
		logic wr_pend;
	} sts_t;

endpackage

@@ hdl/plist_ctrl.sv @@
// ----------------------------------------------------------------------------
// Positional list controller
// Sequences one request: decode and range check, then word shift, count update
// and insert write, or a word read; then holds the result until it is taken.
// ----------------------------------------------------------------------------
module plist_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  plist_pkg::sts_t  sts,
	output plist_pkg::cmd_t  cmd
);

	typedef enum logic [5:0] {
		S_IDLE    = 6'b000001,
		S_DECODE  = 6'b000010,
		S_SHIFT   = 6'b000100,
		S_RD_WAIT = 6'b001000,
		S_FINISH  = 6'b010000,
		S_HOLD    = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_nxt;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_HOLD);

	always_comb begin
		cmd        = '0;
		cmd.status = plist_pkg::ST_OK;
		state_nxt  = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_nxt  = S_DECODE;
				end
			end
			S_DECODE: begin
				if (sts.range_err) begin
					cmd.out_load = 1'b1;
					cmd.status   = plist_pkg::ST_RANGE;
					state_nxt    = S_HOLD;
				end else if (sts.is_insert && sts.full) begin
					cmd.out_load = 1'b1;
					cmd.status   = plist_pkg::ST_FULL;
					state_nxt    = S_HOLD;
				end else if (sts.is_read) begin
					state_nxt = S_RD_WAIT;
				end else begin
					state_nxt = S_SHIFT;
				end
			end
			S_SHIFT: begin
				if (!sts.rem_zero) begin
					cmd.shift = 1'b1;
				end else if (!sts.wr_pend) begin
					state_nxt = S_FINISH;
				end
			end
			S_RD_WAIT: begin
				cmd.out_load = 1'b1;
				cmd.out_rd   = 1'b1;
				state_nxt    = S_HOLD;
			end
			S_FINISH: begin
				cmd.ins_write = sts.is_insert;
				cmd.cnt_inc   = sts.is_insert;
				cmd.cnt_dec   = !sts.is_insert;
				cmd.out_load  = 1'b1;
				state_nxt     = S_HOLD;
			end
			S_HOLD: begin
				if (out_ready) begin
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

@@ hdl/plist_dp.sv @@
// ----------------------------------------------------------------------------
// Positional list datapath
// Word memory with registered read, shift pointer and write stage, element
// count, range checks and the result register.
// ----------------------------------------------------------------------------
module plist_dp #(
	parameter int DEPTH     = plist_pkg::DEPTH_DEF,
	parameter int WORD_BITS = plist_pkg::WORD_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  plist_pkg::cmd_t                      cmd,
	output plist_pkg::sts_t                      sts,
	input  logic [plist_pkg::MODE_W-1:0]         mode,
	input  logic [$clog2(DEPTH+1)-1:0]           position,
	input  logic signed [plist_pkg::VALUE_W-1:0] value,
	output logic signed [plist_pkg::VALUE_W-1:0] read_value,
	output logic [plist_pkg::STATUS_W-1:0]       status,
	output logic [$clog2(DEPTH+1)-1:0]           entry_count
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH+1);

	logic [plist_pkg::MODE_W-1:0]         mode_q;
	logic [CW-1:0]                        pos_q;
	logic signed [plist_pkg::VALUE_W-1:0] value_q;
	logic [CW-1:0]                        count_q;
	logic [CW-1:0]                        count_nxt;
	logic [AW-1:0]                        ptr_q;
	logic [CW-1:0]                        rem_q;
	logic                                 wr_pend_s1;
	logic [AW-1:0]                        wr_addr_s1;
	logic [WORD_BITS-1:0]                 mem [DEPTH];
	logic [WORD_BITS-1:0]                 rdata_q;
	logic [WORD_BITS-1:0]                 value_ext;
	logic                                 mem_we;
	logic [AW-1:0]                        mem_wa;
	logic [WORD_BITS-1:0]                 mem_wd;
	logic                                 is_insert;
	logic                                 is_read;
	logic                                 in_insert;
	logic                                 in_read;
	logic [plist_pkg::VALUE_W-1:0]        read_value_q;
	logic [plist_pkg::STATUS_W-1:0]       status_q;
	logic [CW-1:0]                        entry_count_q;

	assign is_insert = (mode_q == plist_pkg::MODE_INSERT);
	assign is_read   = (mode_q == plist_pkg::MODE_READ);
	assign in_insert = (mode == plist_pkg::MODE_INSERT);
	assign in_read   = (mode == plist_pkg::MODE_READ);

	assign sts.is_insert = is_insert;
	assign sts.is_read   = is_read;
	assign sts.range_err = is_insert ? (pos_q > count_q)
	                                 : ((pos_q == '0) || (pos_q > count_q));
	assign sts.full      = (count_q == CW'(DEPTH));
	assign sts.rem_zero  = (rem_q == '0);
	assign sts.wr_pend   = wr_pend_s1;

	always_comb begin
		count_nxt = count_q;
		if (cmd.cnt_inc) begin
			count_nxt = count_q + CW'(1);
		end else if (cmd.cnt_dec) begin
			count_nxt = count_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			mode_q  <= mode;
			pos_q   <= position;
			value_q <= value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			ptr_q      <= '0;
			rem_q      <= '0;
			wr_pend_s1 <= 1'b0;
			wr_addr_s1 <= '0;
		end else begin
			count_q    <= count_nxt;
			wr_pend_s1 <= cmd.shift;
			if (cmd.accept) begin
				rem_q <= count_q - position;
				if (in_insert) begin
					ptr_q <= AW'(count_q - CW'(1));
				end else if (in_read) begin
					ptr_q <= AW'(position - CW'(1));
				end else begin
					ptr_q <= AW'(position);
				end
			end else if (cmd.shift) begin
				rem_q <= rem_q - CW'(1);
				if (is_insert) begin
					ptr_q      <= ptr_q - AW'(1);
					wr_addr_s1 <= ptr_q + AW'(1);
				end else begin
					ptr_q      <= ptr_q + AW'(1);
					wr_addr_s1 <= ptr_q - AW'(1);
				end
			end
		end
	end

	assign value_ext = WORD_BITS'(value_q);
	assign mem_we    = wr_pend_s1 || cmd.ins_write;
	assign mem_wa    = wr_pend_s1 ? wr_addr_s1 : AW'(pos_q);
	assign mem_wd    = wr_pend_s1 ? rdata_q : value_ext;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rdata_q <= mem[ptr_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			read_value_q  <= cmd.out_rd ? plist_pkg::VALUE_W'(rdata_q) : '0;
			status_q      <= cmd.status;
			entry_count_q <= count_nxt;
		end
	end

	assign read_value  = read_value_q;
	assign status      = status_q;
	assign entry_count = entry_count_q;

endmodule

@@ hdl/positional_list_insert_read_erase.sv @@
// ----------------------------------------------------------------------------
// Positional list with insert, read and erase
// Ordered list of up to DEPTH signed words held in a memory with one write and one read port.
// ----------------------------------------------------------------------------
// The block takes one request at a time and gives one result per request.
// It takes no new request until the result is taken. An insert or erase
// moves the elements behind the position one per cycle through the single
// write port of the word memory while the gap is opened or closed; a read
// or a flagged request moves nothing.
module positional_list_insert_read_erase #(
	parameter int DEPTH     = plist_pkg::DEPTH_DEF,
	parameter int WORD_BITS = plist_pkg::WORD_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [plist_pkg::MODE_W-1:0]         mode,
	input  logic [$clog2(DEPTH+1)-1:0]           position,
	input  logic signed [plist_pkg::VALUE_W-1:0] value,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [plist_pkg::VALUE_W-1:0] read_value,
	output logic [plist_pkg::STATUS_W-1:0]       status,
	output logic [$clog2(DEPTH+1)-1:0]           entry_count
);

	plist_pkg::cmd_t cmd;
	plist_pkg::sts_t sts;

	plist_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	plist_dp #(
		.DEPTH     (DEPTH),
		.WORD_BITS (WORD_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.mode        (mode),
		.position    (position),
		.value       (value),
		.read_value  (read_value),
		.status      (status),
		.entry_count (entry_count)
	);

endmodule

@@ hdl/plist_chk.sv @@
// ----------------------------------------------------------------------------
// Positional list port checker
// Watches the top-level ports for result consistency and handshake holding.
// ----------------------------------------------------------------------------
`include "positional_list_insert_read_erase_macros.svh"

module plist_chk #(
	parameter int DEPTH = plist_pkg::DEPTH_DEF
) (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 in_ready,
	input logic                                 out_valid,
	input logic                                 out_ready,
	input logic signed [plist_pkg::VALUE_W-1:0] read_value,
	input logic [plist_pkg::STATUS_W-1:0]       status,
	input logic [$clog2(DEPTH+1)-1:0]           entry_count
);

	localparam int CW = $clog2(DEPTH+1);
	localparam int BEAT_W = plist_pkg::VALUE_W + plist_pkg::STATUS_W + CW;

	logic              out_stall;
	logic              out_flagged;
	logic              out_full;
	logic [BEAT_W-1:0] out_beat;

	assign out_stall   = out_valid && !out_ready;
	assign out_flagged = out_valid && (status != plist_pkg::ST_OK);
	assign out_full    = out_valid && (status == plist_pkg::ST_FULL);
	assign out_beat    = {read_value, status, entry_count};

	// A pending beat on the result side keeps its payload.
	`PLIST_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_beat), "result changed in stall")

	`PLIST_ASSERT_NOW(a_one_at_a_time, out_valid, !in_ready, "request taken while a result waits")

	`PLIST_ASSERT_NOW(a_flag_zero, out_flagged, read_value == '0, "flagged result carries a value")

	`PLIST_ASSERT_NOW(a_full_count, out_full, entry_count == CW'(DEPTH), "full status below depth")

	`PLIST_ASSERT_NOW(a_count_bound, out_valid, entry_count <= CW'(DEPTH), "count beyond depth")

endmodule

bind positional_list_insert_read_erase plist_chk #(
	.DEPTH (DEPTH)
) u_plist_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.read_value  (read_value),
	.status      (status),
	.entry_count (entry_count)
);
